@@ rtl/rrwd_pkg.sv @@
// Package: constants, types and the arctangent table for the wall distance pipeline
`timescale 1ns / 1ps
package rrwd_pkg;
  localparam int COORD_W = 24;
  localparam int COORD_FRAC_BITS = 12;
  localparam int ANGLE_BITS = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int PHASE_W = 32;
  localparam int CW = 33;
  localparam int OFF_W = 25;
  localparam int QUO_W = 24;
  localparam int DIV_STEPS = 25;
  localparam int NUM_W = OFF_W + 30;
  localparam logic [QUO_W-1:0] DIST_MAX = {QUO_W{1'b1}};
  localparam logic signed [CW-1:0] ONE_Q30 = 33'sd1073741824;
  localparam logic signed [CW-1:0] GAIN_Q30 = 33'sd652032874;
  localparam int CFG_AW = 4;
  localparam logic [CFG_AW-1:0] REG_X_MIN = 4'h0;
  localparam logic [CFG_AW-1:0] REG_X_MAX = 4'h4;
  localparam logic [CFG_AW-1:0] REG_Y_MIN = 4'h8;
  localparam logic [CFG_AW-1:0] REG_Y_MAX = 4'hC;

  function automatic logic signed [PHASE_W:0] atan_val(input int i);
    logic signed [PHASE_W:0] r;
    case (i)
      0: r = 33'sd536870912;   1: r = 33'sd316933406;  2: r = 33'sd167458907;
      3: r = 33'sd85004756;    4: r = 33'sd42667331;   5: r = 33'sd21354465;
      6: r = 33'sd10679838;    7: r = 33'sd5340245;    8: r = 33'sd2670163;
      9: r = 33'sd1335087;     10: r = 33'sd667544;    11: r = 33'sd333772;
      12: r = 33'sd166886;     13: r = 33'sd83443;     14: r = 33'sd41722;
      15: r = 33'sd20861;      16: r = 33'sd10430;     17: r = 33'sd5215;
      18: r = 33'sd2608;       19: r = 33'sd1304;      20: r = 33'sd652;
      21: r = 33'sd326;        22: r = 33'sd163;       23: r = 33'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic [1:0]                quad;
    logic                      exact;
  } ctx_t;

  typedef struct packed {
    logic             hit;
    logic             neg_rem;
    logic [NUM_W-1:0] rem;
    logic [NUM_W-1:0] num;
    logic [CW-1:0]    den;
    logic [QUO_W:0]   quo;
  } div_t;
endpackage

@@ rtl/ray_rectangle_wall_distance.sv @@
// Top level: forward wall distance from position and heading
//  channel | dir | fields
//  in_     | in  | pos_x, pos_y, heading_angle
//  out_    | out | wall_distance, no_hit
//  cfg_    | in  | APB writes and reads of the four wall registers
// One item enters per cycle while the pipeline advances; the path runs through the
// CORDIC cell row and the row of 25 division cells (one quotient bit each).
// The whole pipeline advances only while the output register can take data;
// a skid register keeps in_tready independent of out_tready.
// Reset clears valid bits and loads the wall registers with their reset values.
`timescale 1ns / 1ps
module ray_rectangle_wall_distance #(
  parameter int CORDIC_STAGES = rrwd_pkg::CORDIC_STAGES,
  parameter int ANGLE_BITS    = rrwd_pkg::ANGLE_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [ANGLE_BITS+47:0] in_tdata, // pos_x, pos_y, heading_angle
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // wall_distance
  output logic        out_tuser,  // no_hit
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [rrwd_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import rrwd_pkg::*;
  localparam int LAT = 2 + CORDIC_STAGES + DIV_STEPS;

  logic signed [COORD_W-1:0] xmin_r, xmax_r, ymin_r, ymax_r;
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xmin_r <= '0; xmax_r <= 24'sd16384; ymin_r <= '0; ymax_r <= 24'sd16384;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr)
        REG_X_MIN: xmin_r <= cfg_pwdata[COORD_W-1:0];
        REG_X_MAX: xmax_r <= cfg_pwdata[COORD_W-1:0];
        REG_Y_MIN: ymin_r <= cfg_pwdata[COORD_W-1:0];
        REG_Y_MAX: ymax_r <= cfg_pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (cfg_paddr)
      REG_X_MIN: cfg_prdata = {{8{xmin_r[23]}}, xmin_r};
      REG_X_MAX: cfg_prdata = {{8{xmax_r[23]}}, xmax_r};
      REG_Y_MIN: cfg_prdata = {{8{ymin_r[23]}}, ymin_r};
      REG_Y_MAX: cfg_prdata = {{8{ymax_r[23]}}, ymax_r};
      default:   cfg_prdata = '0;
    endcase
  end

  // skid on input
  logic sk_v_r;
  logic [ANGLE_BITS+47:0] sk_d_r;
  logic adv, v0;
  logic [ANGLE_BITS+47:0] d0;
  logic [LAT-1:0] vld_r;
  logic ov_r;
  assign adv = !ov_r || out_tready;
  assign in_tready = !sk_v_r;
  assign v0 = sk_v_r || in_tvalid;
  assign d0 = sk_v_r ? sk_d_r : in_tdata;
  always_ff @(posedge clk) begin
    if (!rst_n) sk_v_r <= 1'b0;
    else if (adv) sk_v_r <= 1'b0;
    else if (in_tvalid && in_tready) sk_v_r <= 1'b1;
    if (!sk_v_r) sk_d_r <= in_tdata;
  end

  // phase stage
  logic [PHASE_W-1:0] phase;
  logic [1:0] q;
  logic [PHASE_W-1:0] zu;
  assign phase = {d0[ANGLE_BITS+47:48], {(PHASE_W-ANGLE_BITS){1'b0}}};
  assign q = 2'((phase + 32'h2000_0000) >> 30);
  assign zu = phase - {q, 30'd0};

  logic signed [CW-1:0] c_a [CORDIC_STAGES+1];
  logic signed [CW-1:0] s_a [CORDIC_STAGES+1];
  logic signed [PHASE_W:0] z_a [CORDIC_STAGES+1];
  ctx_t ctx_a [CORDIC_STAGES+1];
  ctx_t ctx0;
  assign ctx0.px = d0[23:0];
  assign ctx0.py = d0[47:24];
  assign ctx0.quad = q;
  assign ctx0.exact = (zu == '0);
  always_ff @(posedge clk) begin
    if (adv) begin
      c_a[0] <= GAIN_Q30;
      s_a[0] <= '0;
      z_a[0] <= {zu[PHASE_W-1], zu};
      ctx_a[0] <= ctx0;
    end
  end
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    rrwd_cordic_cell #(.STAGE(g)) u_cell (
      .clk(clk), .en(adv), .c_i(c_a[g]), .s_i(s_a[g]), .z_i(z_a[g]), .ctx_i(ctx_a[g]),
      .c_o(c_a[g+1]), .s_o(s_a[g+1]), .z_o(z_a[g+1]), .ctx_o(ctx_a[g+1]));
  end

  // axis setup
  ctx_t ce;
  logic signed [CW-1:0] c, s, dxv, dyv;
  assign ce = ctx_a[CORDIC_STAGES];
  assign c = ce.exact ? ONE_Q30 : c_a[CORDIC_STAGES];
  assign s = ce.exact ? '0 : s_a[CORDIC_STAGES];
  always_comb begin
    case (ce.quad)
      2'd0: begin dxv = c;  dyv = s;  end
      2'd1: begin dxv = -s; dyv = c;  end
      2'd2: begin dxv = -c; dyv = -s; end
      default: begin dxv = s; dyv = -c; end
    endcase
  end

  function automatic div_t setup(input logic signed [CW-1:0] dir,
      input logic signed [COORD_W-1:0] p, input logic signed [COORD_W-1:0] wmin,
      input logic signed [COORD_W-1:0] wmax);
    div_t d;
    logic signed [OFF_W-1:0] off;
    logic [OFF_W-1:0] om;
    logic [CW-1:0] pre;
    off = dir[CW-1] ? (OFF_W'(wmin) - OFF_W'(p)) : (OFF_W'(wmax) - OFF_W'(p));
    om = off[OFF_W-1] ? -off : off;
    pre = {{(CW-OFF_W-5){1'b0}}, om, 5'd0};
    d.hit = (dir != '0);
    d.neg_rem = (off == '0) || (off[OFF_W-1] != dir[CW-1]);
    d.den = dir[CW-1] ? -dir : dir;
    d.rem = {{(NUM_W-CW){1'b0}}, pre};
    d.num = '0;
    d.quo = '0;
    d.quo[QUO_W] = (pre >= d.den);
    return d;
  endfunction

  div_t dx_a [DIV_STEPS+1];
  div_t dy_a [DIV_STEPS+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      dx_a[0] <= setup(dxv, ce.px, xmin_r, xmax_r);
      dy_a[0] <= setup(dyv, ce.py, ymin_r, ymax_r);
    end
  end
  // preload the remainder with offset * 2^5 and flag saturation when it already
  // reaches the divisor; the cells then form quotient bits 24 down to 0
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    rrwd_div_cell u_div (
      .clk(clk), .en(adv), .dx_i(dx_a[g]), .dy_i(dy_a[g]),
      .dx_o(dx_a[g+1]), .dy_o(dy_a[g+1]));
  end

  // final select
  div_t fx, fy;
  logic [QUO_W-1:0] qx, qy, best;
  logic hx, hy;
  assign fx = dx_a[DIV_STEPS];
  assign fy = dy_a[DIV_STEPS];
  assign hx = fx.hit;
  assign hy = fy.hit;
  assign qx = fx.neg_rem ? '0 : (fx.quo[QUO_W] ? DIST_MAX : fx.quo[QUO_W-1:0]);
  assign qy = fy.neg_rem ? '0 : (fy.quo[QUO_W] ? DIST_MAX : fy.quo[QUO_W-1:0]);
  always_comb begin
    if (hx && hy) best = (qx < qy) ? qx : qy;
    else if (hx) best = qx;
    else if (hy) best = qy;
    else best = DIST_MAX;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      ov_r <= 1'b0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], v0};
      ov_r <= vld_r[LAT-1];
    end
    if (adv) begin
      out_tdata <= best;
      out_tuser <= !(hx || hy);
    end
  end
  assign out_tvalid = ov_r;
endmodule

@@ rtl/rrwd_cordic_cell.sv @@
// One CORDIC rotation cell of the heading pipeline
`timescale 1ns / 1ps
module rrwd_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [rrwd_pkg::CW-1:0]  c_i,
  input  logic signed [rrwd_pkg::CW-1:0]  s_i,
  input  logic signed [rrwd_pkg::PHASE_W:0] z_i,
  input  rrwd_pkg::ctx_t                  ctx_i,
  output logic signed [rrwd_pkg::CW-1:0]  c_o,
  output logic signed [rrwd_pkg::CW-1:0]  s_o,
  output logic signed [rrwd_pkg::PHASE_W:0] z_o,
  output rrwd_pkg::ctx_t                  ctx_o
);
  import rrwd_pkg::*;
  logic signed [CW-1:0] c_r, s_r;
  logic signed [PHASE_W:0] z_r;
  ctx_t ctx_r;
  always_ff @(posedge clk) begin
    if (en) begin
      if (z_i >= 0) begin
        c_r <= c_i - (s_i >>> STAGE);
        s_r <= s_i + (c_i >>> STAGE);
        z_r <= z_i - atan_val(STAGE);
      end else begin
        c_r <= c_i + (s_i >>> STAGE);
        s_r <= s_i - (c_i >>> STAGE);
        z_r <= z_i + atan_val(STAGE);
      end
      ctx_r <= ctx_i;
    end
  end
  assign c_o = c_r;
  assign s_o = s_r;
  assign z_o = z_r;
  assign ctx_o = ctx_r;
endmodule

@@ rtl/rrwd_div_cell.sv @@
// One restoring division cell: one quotient bit for each axis per cycle while en is high
`timescale 1ns / 1ps
module rrwd_div_cell (
  input  logic           clk,
  input  logic           en,
  input  rrwd_pkg::div_t dx_i,
  input  rrwd_pkg::div_t dy_i,
  output rrwd_pkg::div_t dx_o,
  output rrwd_pkg::div_t dy_o
);
  import rrwd_pkg::*;
  div_t dx_r, dy_r;

  function automatic div_t step(input div_t d);
    div_t r;
    logic [NUM_W:0] sh;
    logic [NUM_W:0] df;
    r = d;
    sh = {d.rem, d.num[NUM_W-1]};
    df = sh - {{(NUM_W+1-CW){1'b0}}, d.den};
    r.num = {d.num[NUM_W-2:0], 1'b0};
    if (!df[NUM_W]) begin
      r.rem = df[NUM_W-1:0];
      r.quo = {d.quo[QUO_W-1:0], 1'b1};
      if (d.quo[QUO_W]) r.quo[QUO_W] = 1'b1;
    end else begin
      r.rem = sh[NUM_W-1:0];
      r.quo = {d.quo[QUO_W-1:0], 1'b0};
      if (d.quo[QUO_W]) r.quo[QUO_W] = 1'b1;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= step(dx_i);
      dy_r <= step(dy_i);
    end
  end
  assign dx_o = dx_r;
  assign dy_o = dy_r;
endmodule

@@ test/rrwd_checker.sv @@
// Checker: predicts wall distance results from observed transactions and compares them
`timescale 1ns / 1ps
module rrwd_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [rrwd_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending_count
);
  import rrwd_pkg::*;

  typedef struct {
    logic [23:0] wall_span;
    logic        miss;
  } range_t;

  range_t range_q[$];
  logic signed [23:0] wx_lo, wx_hi, wy_lo, wy_hi;
  int mismatches;

  function automatic longint turn_step(input int i);
    longint tab[24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                        10679838, 5340245, 2670163, 1335087, 667544, 333772,
                        166886, 83443, 41722, 20861, 10430, 5215,
                        2608, 1304, 652, 326, 163, 81};
    return tab[i];
  endfunction

  function automatic bit span_to_wall(input longint p, input longint lo, input longint hi,
                                      input longint dir, output longint unsigned span);
    longint off;
    longint unsigned num, den;
    span = 0;
    if (dir == 0) return 0;
    off = ((dir < 0) ? lo : hi) - p;
    if (off == 0 || ((off < 0) != (dir < 0))) return 1;
    num = (off < 0) ? -off : off;
    den = (dir < 0) ? -dir : dir;
    span = (num << 30) / den;
    if (span > 64'd16777215) span = 64'd16777215;
    return 1;
  endfunction

  function automatic range_t predict_range(input logic [63:0] d);
    longint px, py, c, s, z, cs, ss, dx, dy;
    longint unsigned phase, q, zu, sx, sy, best;
    bit hx, hy;
    range_t r;
    px = longint'($signed(d[23:0]));
    py = longint'($signed(d[47:24]));
    phase = longint'(d[63:48]) << 16;
    q = ((phase + 64'h20000000) >> 30) & 3;
    zu = (phase - (q << 30)) & 64'hFFFFFFFF;
    z = (zu >= 64'h80000000) ? longint'(zu) - 64'sh100000000 : longint'(zu);
    if (z == 0) begin
      c = 1073741824;
      s = 0;
    end else begin
      c = 652032874;
      s = 0;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        cs = c >>> i;
        ss = s >>> i;
        if (z >= 0) begin
          c -= ss; s += cs; z -= turn_step(i);
        end else begin
          c += ss; s -= cs; z += turn_step(i);
        end
      end
    end
    case (q)
      0: begin dx = c; dy = s; end
      1: begin dx = -s; dy = c; end
      2: begin dx = -c; dy = -s; end
      default: begin dx = s; dy = -c; end
    endcase
    hx = span_to_wall(px, wx_lo, wx_hi, dx, sx);
    hy = span_to_wall(py, wy_lo, wy_hi, dy, sy);
    if (hx && hy) best = (sx < sy) ? sx : sy;
    else if (hx) best = sx;
    else if (hy) best = sy;
    else best = 64'd16777215;
    r.wall_span = best[23:0];
    r.miss = !(hx || hy);
    return r;
  endfunction

  always @(posedge clk) begin
    range_t e;
    if (!rst_n) begin
      wx_lo <= 0; wx_hi <= 24'sd16384; wy_lo <= 0; wy_hi <= 24'sd16384;
      range_q.delete();
      fail_count <= 0;
      mismatches = 0;
    end else begin
      if (in_tvalid && in_tready) range_q.push_back(predict_range(in_tdata));
      if (out_tvalid && out_tready) begin
        if (range_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (mismatches < 10) $display("unexpected result %0d/%0b", out_tdata, out_tuser);
          mismatches++;
        end else begin
          e = range_q.pop_front();
          if (e.wall_span !== out_tdata || e.miss !== out_tuser) begin
            fail_count <= fail_count + 1;
            if (mismatches < 10)
              $display("mismatch: exp dist %0d no_hit %0b, got dist %0d no_hit %0b",
                       e.wall_span, e.miss, out_tdata, out_tuser);
            mismatches++;
          end
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr)
          REG_X_MIN: wx_lo <= cfg_pwdata[23:0];
          REG_X_MAX: wx_hi <= cfg_pwdata[23:0];
          REG_Y_MIN: wy_lo <= cfg_pwdata[23:0];
          REG_Y_MAX: wy_hi <= cfg_pwdata[23:0];
          default: ;
        endcase
      end
    end
  end

  assign pending_count = range_q.size();
endmodule

@@ test/tb_ray_rectangle_wall_distance.sv @@
// Testbench top: drives queries and wall settings, judges the run
`timescale 1ns / 1ps
module tb_ray_rectangle_wall_distance;
  import rrwd_pkg::*;

  localparam int LATENCY = 2 + CORDIC_STAGES + 26;
  localparam int STALL_LIMIT = 20000;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, out_tuser;
  logic [63:0] in_tdata;
  logic [23:0] out_tdata;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  int fail_count, pending_count;
  int send_idle, recv_idle;
  bit hold_recv;
  int quiet_cycles;

  ray_rectangle_wall_distance dut (.*);

  rrwd_checker chk (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (hold_recv) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_wall(input logic [CFG_AW-1:0] addr, input logic [23:0] val);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= addr; cfg_pwdata <= {8'h0, val};
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
  endtask

  task automatic send_query(input logic [23:0] px, input logic [23:0] py,
                            input logic [15:0] ang);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {ang, py, px};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_room(input logic [23:0] a, input logic [23:0] b,
                          input logic [23:0] c, input logic [23:0] d);
    drain();
    write_wall(REG_X_MIN, a); write_wall(REG_X_MAX, b);
    write_wall(REG_Y_MIN, c); write_wall(REG_Y_MAX, d);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  function automatic logic [23:0] near_wall(input logic [23:0] w);
    return 24'((w + $urandom_range(8192)) - 4096);
  endfunction

  task automatic random_queries(input int n, input logic [23:0] xl, input logic [23:0] xh,
                                input logic [23:0] yl, input logic [23:0] yh);
    logic [23:0] px, py;
    logic [15:0] ang;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(3))
        0: begin px = 24'($urandom); py = 24'($urandom); end
        1: begin px = near_wall($urandom_range(1) ? xl : xh);
                 py = near_wall($urandom_range(1) ? yl : yh); end
        default: begin
          px = 24'(xl + $urandom_range(16384)); py = 24'(yl + $urandom_range(16384));
        end
      endcase
      case ($urandom_range(4))
        0: ang = 16'($urandom_range(3) * 16384);
        1: ang = 16'($urandom_range(3) * 16384 + $urandom_range(8) - 4);
        default: ang = 16'($urandom);
      endcase
      send_query(px, py, ang);
    end
  endtask

  initial begin
    rst_n = 0; in_tvalid = 0; in_tdata = '0; out_tready = 0; hold_recv = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = '0; cfg_pwdata = '0;
    send_idle = 18; recv_idle = 87; quiet_cycles = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_query(24'd8192, 24'd8192, 16'd0);
    send_query(24'd8192, 24'd8192, 16'd16384);
    send_query(24'd8192, 24'd8192, 16'd32768);
    send_query(24'd8192, 24'd8192, 16'd49152);
    send_query(24'd8192, 24'd8192, 16'd8192);
    send_query(24'd8192, 24'd8192, 16'd1);
    send_query(24'd8192, 24'd8192, 16'hFFFF);
    send_query(24'h7FFFFF, 24'h800000, 16'd24576);
    send_query(24'h800000, 24'h7FFFFF, 16'd40960);
    send_query(24'd16384, 24'd0, 16'd0);
    send_query(24'd0, 24'd0, 16'd100);
    send_query(24'hFFFFFF, 24'hFFFFFF, 16'd16385);
    send_query(24'd8192, 24'd8192, 16'd16383);
    send_query(24'h800000, 24'h800000, 16'd1);
    set_room(24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    send_query(24'd0, 24'd0, 16'd1);
    send_query(24'd0, 24'd0, 16'd40000);
    send_query(24'h7FFFFF, 24'h7FFFFF, 16'd0);
    set_room(24'd16384, 24'd0, 24'd16384, 24'd0);
    send_query(24'd8192, 24'd8192, 16'd5000);
    send_query(24'd8192, 24'd8192, 16'd37000);

    set_room(24'hFF0000, 24'h010000, 24'hFF8000, 24'h020000);
    random_queries(300, 24'hFF0000, 24'h010000, 24'hFF8000, 24'h020000);

    hold_recv = 1;
    fork
      begin repeat (400) @(posedge clk); hold_recv = 0; end
      random_queries(100, 24'hFF0000, 24'h010000, 24'hFF8000, 24'h020000);
    join
    hold_recv = 0;

    send_idle = 87; recv_idle = 18;
    set_room(24'h000000, 24'h004000, 24'h000000, 24'h004000);
    random_queries(250, 24'h000000, 24'h004000, 24'h000000, 24'h004000);

    send_idle = 0; recv_idle = 0;
    set_room(24'h800000, 24'h7FFFFF, 24'hFFF000, 24'h001000);
    random_queries(150, 24'h800000, 24'h7FFFFF, 24'hFFF000, 24'h001000);
    set_room(24'h400000, 24'hC00000, 24'h123456, 24'hFEDCBA);
    random_queries(130, 24'h400000, 24'hC00000, 24'h123456, 24'hFEDCBA);

    drain();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
